@@ design/zsbc_pkg.sv @@
package zsbc_pkg;

   localparam int OUT_BITS  = 48;
   localparam int WIDE_BITS = 64;
   localparam int N_CLASS   = 10;

   localparam logic [31:0] LOCAL_SIG = 32'h04034b50;

   // signature byte index of the last signature byte
   localparam logic [4:0] SIG_LAST   = 5'd3;
   // header byte positions
   localparam logic [4:0] POS_METH_L = 5'd4;
   localparam logic [4:0] POS_METH_H = 5'd5;
   localparam logic [4:0] POS_SIZE_0 = 5'd14;
   localparam logic [4:0] POS_SIZE_1 = 5'd15;
   localparam logic [4:0] POS_SIZE_2 = 5'd16;
   localparam logic [4:0] POS_SIZE_3 = 5'd17;
   localparam logic [4:0] POS_NAME_L = 5'd22;
   localparam logic [4:0] POS_NAME_H = 5'd23;
   localparam logic [4:0] POS_EXTR_L = 5'd24;
   localparam logic [4:0] POS_EXTR_H = 5'd25;

   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_NL      = 8'd10;
   localparam logic [7:0] CH_LBRACE  = 8'd123;
   localparam logic [7:0] CH_RBRACE  = 8'd125;
   localparam logic [7:0] CH_QUOTE   = 8'd34;
   localparam logic [7:0] CH_COLON   = 8'd58;
   localparam logic [7:0] CH_COMMA   = 8'd44;

   localparam int CI_BYTES = 0;
   localparam int CI_HIBIT = 1;
   localparam int CI_SPACE = 2;
   localparam int CI_NL    = 3;
   localparam int CI_BRACE = 4;
   localparam int CI_QUOTE = 5;
   localparam int CI_COLON = 6;
   localparam int CI_COMMA = 7;
   localparam int CI_OK    = 8;
   localparam int CI_SKIP  = 9;

   localparam logic [1:0] ST_BETWEEN = 2'd0;
   localparam logic [1:0] ST_BAD_SIG = 2'd1;
   localparam logic [1:0] ST_INSIDE  = 2'd2;

   typedef enum logic [2:0] {
      PH_SIG  = 3'd0,
      PH_HDR  = 3'd1,
      PH_SKIP = 3'd2,
      PH_DATA = 3'd3,
      PH_STOP = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] byte_count;
      logic [OUT_BITS-1:0] high_bit_count;
      logic [OUT_BITS-1:0] space_count;
      logic [OUT_BITS-1:0] newline_count;
      logic [OUT_BITS-1:0] brace_count;
      logic [OUT_BITS-1:0] quote_count;
      logic [OUT_BITS-1:0] colon_count;
      logic [OUT_BITS-1:0] comma_count;
      logic [OUT_BITS-1:0] stored_files;
      logic [OUT_BITS-1:0] skipped_files;
      logic [1:0]          end_status;
   } rsp_type;

   // events from the parser to the counter bank for one item
   typedef struct packed {
      logic       count_data;
      logic [7:0] data_byte;
      logic       entry_ok;
      logic       entry_skip;
   } hit_type;

endpackage

@@ design/zsbc_parser.sv @@
module zsbc_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  zsbc_pkg::req_type item,
   output zsbc_pkg::hit_type hit,
   output logic [1:0]       end_status
);
   import zsbc_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic        sig_ok_ff, sig_ok_in;
   logic [15:0] method_ff, method_in;
   logic [31:0] size_ff, size_in;
   logic [15:0] name_ff, name_in;
   logic [15:0] extra_ff, extra_in;
   logic [31:0] left_ff, left_in;

   logic [7:0]  b;
   logic [7:0]  sig_byte;
   logic        sig_ok_n;
   logic [16:0] skip_sum;
   logic        begin_data;
   logic        finish;

   assign b        = item.data_byte;
   assign sig_byte = LOCAL_SIG[{pos_ff[1:0], 3'b000} +: 8];
   assign sig_ok_n = sig_ok_ff & (b == sig_byte);
   // name length is complete here; extra length high byte is arriving now
   assign skip_sum = {1'b0, name_ff} + {1'b0, b, extra_ff[7:0]};

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      sig_ok_in  = sig_ok_ff;
      method_in  = method_ff;
      size_in    = size_ff;
      name_in    = name_ff;
      extra_in   = extra_ff;
      left_in    = left_ff;
      begin_data = 1'b0;
      finish     = 1'b0;
      hit        = '0;
      hit.data_byte = b;

      case (phase_ff)
         PH_SIG: begin
            sig_ok_in = sig_ok_n;
            pos_in    = pos_ff + 5'd1;
            if (pos_ff == SIG_LAST) begin
               if (sig_ok_n) begin
                  phase_in  = PH_HDR;
                  pos_in    = '0;
                  method_in = '0;
                  size_in   = '0;
                  name_in   = '0;
                  extra_in  = '0;
               end else begin
                  phase_in = PH_STOP;
               end
            end
         end
         PH_HDR: begin
            pos_in = pos_ff + 5'd1;
            if (pos_ff == POS_METH_L) method_in[7:0]   = b;
            if (pos_ff == POS_METH_H) method_in[15:8]  = b;
            if (pos_ff == POS_SIZE_0) size_in[7:0]     = b;
            if (pos_ff == POS_SIZE_1) size_in[15:8]    = b;
            if (pos_ff == POS_SIZE_2) size_in[23:16]   = b;
            if (pos_ff == POS_SIZE_3) size_in[31:24]   = b;
            if (pos_ff == POS_NAME_L) name_in[7:0]     = b;
            if (pos_ff == POS_NAME_H) name_in[15:8]    = b;
            if (pos_ff == POS_EXTR_L) extra_in[7:0]    = b;
            if (pos_ff == POS_EXTR_H) begin
               extra_in[15:8] = b;
               pos_in         = '0;
               if (skip_sum == '0) begin
                  begin_data = 1'b1;
               end else begin
                  phase_in = PH_SKIP;
                  left_in  = 32'(skip_sum);
               end
            end
         end
         PH_SKIP: begin
            left_in = left_ff - 32'd1;
            if (left_ff == 32'd1) begin_data = 1'b1;
         end
         PH_DATA: begin
            hit.count_data = (method_ff == '0);
            left_in        = left_ff - 32'd1;
            if (left_ff == 32'd1) finish = 1'b1;
         end
         default: ;
      endcase

      if (begin_data) begin
         left_in = size_ff;
         if (size_ff == '0) finish = 1'b1;
         else phase_in = PH_DATA;
      end

      if (finish) begin
         hit.entry_ok   = (method_ff == '0);
         hit.entry_skip = (method_ff != '0);
         phase_in       = PH_SIG;
         pos_in         = '0;
         sig_ok_in      = 1'b1;
      end

      case (phase_in)
         PH_STOP: end_status = ST_BAD_SIG;
         PH_SIG:  end_status = ST_BETWEEN;
         default: end_status = ST_INSIDE;
      endcase

      // end of stream: report, then start over
      if (item.end_of_stream) begin
         phase_in  = PH_SIG;
         pos_in    = '0;
         sig_ok_in = 1'b1;
         method_in = '0;
         size_in   = '0;
         name_in   = '0;
         extra_in  = '0;
         left_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SIG;
         pos_ff    <= '0;
         sig_ok_ff <= 1'b1;
         method_ff <= '0;
         size_ff   <= '0;
         name_ff   <= '0;
         extra_ff  <= '0;
         left_ff   <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         sig_ok_ff <= sig_ok_in;
         method_ff <= method_in;
         size_ff   <= size_in;
         name_ff   <= name_in;
         extra_ff  <= extra_in;
         left_ff   <= left_in;
      end
   end

endmodule

@@ design/zsbc_counters.sv @@
module zsbc_counters #(
   parameter int COUNTER_BITS = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic                    clear,
   input  zsbc_pkg::hit_type       hit,
   output logic [COUNTER_BITS-1:0] cnt_next [zsbc_pkg::N_CLASS]
);
   import zsbc_pkg::*;

   logic [COUNTER_BITS-1:0] cnt_ff [N_CLASS];
   logic [N_CLASS-1:0]      bump;

   always_comb begin
      bump           = '0;
      bump[CI_BYTES] = hit.count_data;
      bump[CI_HIBIT] = hit.count_data & hit.data_byte[7];
      bump[CI_SPACE] = hit.count_data & (hit.data_byte == CH_SPACE);
      bump[CI_NL]    = hit.count_data & (hit.data_byte == CH_NL);
      bump[CI_BRACE] = hit.count_data & ((hit.data_byte == CH_LBRACE) ||
                                         (hit.data_byte == CH_RBRACE));
      bump[CI_QUOTE] = hit.count_data & (hit.data_byte == CH_QUOTE);
      bump[CI_COLON] = hit.count_data & (hit.data_byte == CH_COLON);
      bump[CI_COMMA] = hit.count_data & (hit.data_byte == CH_COMMA);
      bump[CI_OK]    = hit.entry_ok;
      bump[CI_SKIP]  = hit.entry_skip;
   end

   for (genvar i = 0; i < N_CLASS; i++) begin : g_cnt
      // saturate at all ones
      assign cnt_next[i] = (bump[i] && !(&cnt_ff[i])) ?
                           cnt_ff[i] + COUNTER_BITS'(1) : cnt_ff[i];

      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff[i] <= '0;
         end else if (fire) begin
            cnt_ff[i] <= clear ? '0 : cnt_next[i];
         end
      end
   end

endmodule

@@ design/zip_stored_byte_class_counter.sv @@
// Channel  Dir  Handshake              Payload
// req      in   req_valid / req_ready  req_item : zsbc_pkg::req_type (one archive byte)
// rsp      out  rsp_valid / rsp_ready  rsp_item : zsbc_pkg::rsp_type (counters, status)
//
// One byte per cycle sustained: an input register feeds the parser and the
// saturating counter bank, whose next values land in the result register.
// A result is captured in the result register when its end-of-stream byte leaves the input register.
// Only an end-of-stream byte waits on a full result register; other bytes
// keep flowing while a result is held. Reset is synchronous and clears all
// parse state and counters.
module zip_stored_byte_class_counter #(
   parameter int COUNTER_BITS = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  zsbc_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output zsbc_pkg::rsp_type rsp_item
);
   import zsbc_pkg::*;

   logic                    in_valid_ff;
   req_type                 in_item_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_item_ff, rsp_item_in;
   logic                    fire;
   logic                    last;
   hit_type                 hit;
   logic [1:0]              end_status;
   logic [COUNTER_BITS-1:0] cnt_next [N_CLASS];
   logic [WIDE_BITS-1:0]    wide [N_CLASS];

   assign last      = in_item_ff.end_of_stream;
   // the last byte of a stream needs room in the result register
   assign fire      = in_valid_ff && (!last || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   zsbc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (in_item_ff),
      .hit        (hit),
      .end_status (end_status)
   );

   zsbc_counters #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_counters (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .clear    (last),
      .hit      (hit),
      .cnt_next (cnt_next)
   );

   for (genvar i = 0; i < N_CLASS; i++) begin : g_wide
      assign wide[i] = WIDE_BITS'(cnt_next[i]);
   end

   always_comb begin
      rsp_item_in.byte_count     = wide[CI_BYTES][OUT_BITS-1:0];
      rsp_item_in.high_bit_count = wide[CI_HIBIT][OUT_BITS-1:0];
      rsp_item_in.space_count    = wide[CI_SPACE][OUT_BITS-1:0];
      rsp_item_in.newline_count  = wide[CI_NL][OUT_BITS-1:0];
      rsp_item_in.brace_count    = wide[CI_BRACE][OUT_BITS-1:0];
      rsp_item_in.quote_count    = wide[CI_QUOTE][OUT_BITS-1:0];
      rsp_item_in.colon_count    = wide[CI_COLON][OUT_BITS-1:0];
      rsp_item_in.comma_count    = wide[CI_COMMA][OUT_BITS-1:0];
      rsp_item_in.stored_files   = wide[CI_OK][OUT_BITS-1:0];
      rsp_item_in.skipped_files  = wide[CI_SKIP][OUT_BITS-1:0];
      rsp_item_in.end_status     = end_status;

      rsp_valid_in = rsp_valid_ff;
      if (fire && last) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_item_ff <= req_item;
      if (fire && last) rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
